[src/software_timer_bank_defines.svh]
// Assertion macros shared by the timer bank RTL.
`ifndef SOFTWARE_TIMER_BANK_DEFINES_SVH
`define SOFTWARE_TIMER_BANK_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequence must hold in the same cycle as the antecedent.
`define STB_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("timer bank check failed");

// Consequence must hold in the cycle after the antecedent.
`define STB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("timer bank check failed");

`else

`define STB_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define STB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[src/stb_pkg.sv]
// Types and constants shared by the timer bank modules.
`default_nettype none

package stb_pkg;

    localparam int IDX_W = 4;
    localparam int RELOAD_IN_W = 16;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [1:0] {
        MODE_STOP  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_START = 2'd2,
        MODE_RESET = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WR_UPD,
        ST_WALK,
        ST_FLUSH
    } state_t;

    // Control from the sequencer to the result queue.
    typedef struct packed {
        logic             push;
        logic             flush;
        logic [IDX_W-1:0] index;
    } rq_ctrl_t;

    // Status from the result queue back to the sequencer.
    typedef struct packed {
        logic pend_valid;
        logic can_push;
    } rq_stat_t;

endpackage

`default_nettype wire

[src/stb_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module stb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]                        wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [DATA_W-1:0]                        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/stb_timer_alu.sv]
// Shared update unit: next mode and counter of one timer entry for one tick.
`default_nettype none

module stb_timer_alu #(
    parameter int CNT_W = 16
) (
    input  wire stb_pkg::mode_t    in_mode,
    input  wire logic [CNT_W-1:0]  in_count,
    input  wire logic [CNT_W-1:0]  in_reload,
    input  wire logic              in_restart,
    input  wire logic              in_notify,
    output stb_pkg::mode_t         out_mode,
    output logic      [CNT_W-1:0]  out_count,
    output logic                   emit
);

    logic at_zero;

    assign at_zero = (in_count == '0);

    always_comb begin
        out_mode  = in_mode;
        out_count = in_count;
        emit      = 1'b0;
        case (in_mode)
            stb_pkg::MODE_RUN: begin
                if (at_zero) begin
                    if (in_restart) begin
                        out_count = in_reload;
                    end else begin
                        out_mode = stb_pkg::MODE_STOP;
                    end
                    emit = in_notify;
                end else begin
                    out_count = in_count - CNT_W'(1);
                end
            end
            stb_pkg::MODE_START: begin
                out_count = in_reload;
                out_mode  = stb_pkg::MODE_RUN;
            end
            stb_pkg::MODE_RESET: begin
                out_mode = stb_pkg::MODE_START;
            end
            default: begin
                out_mode = in_mode;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/stb_result_q.sv]
// Result queue: one pending expiry plus the output register of the result stream.
`default_nettype none

module stb_result_q (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire stb_pkg::rq_ctrl_t ctrl,
    output stb_pkg::rq_stat_t      stat,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // [3:0] expired_index, [7:4] zero
    output logic                   m_tlast
);

    logic                          pend_valid_reg;
    logic [stb_pkg::IDX_W-1:0]     pend_idx_reg;
    logic                          out_valid_reg;
    logic [stb_pkg::IDX_W-1:0]     out_idx_reg;
    logic                          out_last_reg;
    logic                          out_free;
    logic                          load_out;

    // The held expiry is only known to be the last of a tick once the walk
    // has finished, so it leaves either when a newer one arrives or on flush.
    assign out_free = !out_valid_reg || m_tready;
    assign load_out = pend_valid_reg && (ctrl.push || (ctrl.flush && out_free));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (ctrl.push) begin
                pend_valid_reg <= 1'b1;
            end else if (load_out) begin
                pend_valid_reg <= 1'b0;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            pend_idx_reg <= ctrl.index;
        end
        if (load_out) begin
            out_idx_reg  <= pend_idx_reg;
            out_last_reg <= ctrl.flush;
        end
    end

    assign stat.pend_valid = pend_valid_reg;
    assign stat.can_push   = !pend_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(8 - stb_pkg::IDX_W)'(0), out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

[src/software_timer_bank.sv]
// Top level of the reloadable countdown timer bank.
//
// A bank of NUM_TIMERS countdown timers whose entries live in one RAM, walked
// by a small sequencer that feeds each entry through one shared update unit.
// A write beat (tuser high) sets a timer's mode, reload value and flags: the
// entry is read, then written back with its counter kept; writes to an index
// beyond the bank are dropped without a RAM access. A tick beat (tuser low)
// reads the first entry, then updates each timer in turn and writes its entry
// back while the next is read, and ends in a flush step that releases the
// final result. The single read and single write port of the entry RAM sets
// this overlap. The walk pauses for as long as the result output is held back
// while a further expiry is found. Every timer reads as stopped and zero after
// reset, with no clearing pass. Each notifying expiry emits its index; the
// final one of a tick carries tlast.
`default_nettype none
`include "software_timer_bank_defines.svh"

module software_timer_bank #(
    parameter int NUM_TIMERS  = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [3:0] timer_index, [5:4] mode, [21:6] reload, [22] auto_restart, [23] notify
    input  wire logic [23:0] s_tdata,
    input  wire logic        s_tuser,   // [0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [3:0] expired_index, [7:4] zero
    output logic             m_tlast
);

    localparam int AW     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int IW     = stb_pkg::IDX_W;
    localparam int CW     = COUNT_WIDTH;
    // Entry layout from bit 0: mode, counter, reload, restart, notify.
    localparam int CNT_LO = 2;
    localparam int REL_LO = CNT_LO + CW;
    localparam int RST_B  = REL_LO + CW;
    localparam int NTF_B  = RST_B + 1;
    localparam int DW     = NTF_B + 1;

    stb_pkg::state_t    state_reg, state_next;
    logic [AW-1:0]      proc_cnt_reg;
    logic [NUM_TIMERS-1:0] valid_reg;
    logic               rd_vld_reg;
    logic [AW-1:0]      wr_addr_reg;
    stb_pkg::mode_t     wr_mode_reg;
    logic [CW-1:0]      wr_reload_reg;
    logic               wr_restart_reg;
    logic               wr_notify_reg;

    logic [IW-1:0]      in_index;
    logic               accept;
    logic               in_range;
    logic               last_entry;
    logic               stall;

    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [DW-1:0]      ram_wr_data;
    logic [DW-1:0]      ram_rd_data;
    logic [DW-1:0]      ent;

    stb_pkg::mode_t     ent_mode;
    stb_pkg::mode_t     alu_mode;
    logic [CW-1:0]      alu_count;
    logic               alu_emit;

    stb_pkg::rq_ctrl_t  rq_ctrl;
    stb_pkg::rq_stat_t  rq_stat;

    assign in_index   = s_tdata[3:0];
    assign accept     = s_tvalid && s_tready;
    assign in_range   = 32'(in_index) < 32'(NUM_TIMERS);
    assign last_entry = (proc_cnt_reg == AW'(NUM_TIMERS - 1));

    // An entry never written since reset reads as a stopped, cleared timer.
    assign ent      = rd_vld_reg ? ram_rd_data : '0;
    assign ent_mode = stb_pkg::mode_t'(ent[1:0]);

    stb_ram #(
        .DATA_W (DW),
        .DEPTH  (NUM_TIMERS)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    stb_timer_alu #(
        .CNT_W (CW)
    ) u_alu (
        .in_mode    (ent_mode),
        .in_count   (ent[REL_LO-1:CNT_LO]),
        .in_reload  (ent[RST_B-1:REL_LO]),
        .in_restart (ent[RST_B]),
        .in_notify  (ent[NTF_B]),
        .out_mode   (alu_mode),
        .out_count  (alu_count),
        .emit       (alu_emit)
    );

    stb_result_q u_rq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (rq_ctrl),
        .stat     (rq_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The walk holds its place when an expiry cannot be queued.
    assign stall = (state_reg == stb_pkg::ST_WALK) && alu_emit && !rq_stat.can_push;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            stb_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == stb_pkg::OP_TICK) begin
                        state_next = stb_pkg::ST_WALK;
                    end else if (in_range) begin
                        state_next = stb_pkg::ST_WR_UPD;
                    end
                end
            end
            stb_pkg::ST_WR_UPD: begin
                state_next = stb_pkg::ST_IDLE;
            end
            stb_pkg::ST_WALK: begin
                if (!stall && last_entry) begin
                    state_next = stb_pkg::ST_FLUSH;
                end
            end
            stb_pkg::ST_FLUSH: begin
                if (rq_stat.can_push) begin
                    state_next = stb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = '0;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = proc_cnt_reg;
        ram_wr_data   = {ent[NTF_B], ent[RST_B], ent[RST_B-1:REL_LO], alu_count, alu_mode};
        rq_ctrl.push  = 1'b0;
        rq_ctrl.flush = 1'b0;
        rq_ctrl.index = IW'(proc_cnt_reg);
        case (state_reg)
            stb_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == stb_pkg::OP_TICK) begin
                        ram_rd_en = 1'b1;
                    end else if (in_range) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(in_index);
                    end
                end
            end
            stb_pkg::ST_WR_UPD: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = wr_addr_reg;
                ram_wr_data = {wr_notify_reg, wr_restart_reg, wr_reload_reg,
                               ent[REL_LO-1:CNT_LO], wr_mode_reg};
            end
            stb_pkg::ST_WALK: begin
                if (!stall) begin
                    ram_wr_en    = 1'b1;
                    rq_ctrl.push = alu_emit;
                    ram_rd_en    = !last_entry;
                    ram_rd_addr  = proc_cnt_reg + AW'(1);
                end
            end
            stb_pkg::ST_FLUSH: begin
                rq_ctrl.flush = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= stb_pkg::ST_IDLE;
            proc_cnt_reg <= '0;
            valid_reg    <= '0;
            rd_vld_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                proc_cnt_reg <= '0;
            end else if ((state_reg == stb_pkg::ST_WALK) && !stall) begin
                proc_cnt_reg <= proc_cnt_reg + AW'(1);
            end
            if (ram_wr_en) begin
                valid_reg[ram_wr_addr] <= 1'b1;
            end
            if (ram_rd_en) begin
                rd_vld_reg <= valid_reg[ram_rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            wr_addr_reg    <= AW'(in_index);
            wr_mode_reg    <= stb_pkg::mode_t'(s_tdata[5:4]);
            wr_reload_reg  <= CW'(s_tdata[21:6]);
            wr_restart_reg <= s_tdata[22];
            wr_notify_reg  <= s_tdata[23];
        end
    end

    `STB_ASSERT_SAME(a_push_has_room, aclk, aresetn, rq_ctrl.push, rq_stat.can_push)
    `STB_ASSERT_SAME(a_stall_only_when_blocked, aclk, aresetn, stall, m_tvalid && !m_tready)
    `STB_ASSERT_NEXT(a_tick_starts_walk, aclk, aresetn, accept && (s_tuser == stb_pkg::OP_TICK), state_reg == stb_pkg::ST_WALK)
    `STB_ASSERT_SAME(a_idle_queue_drained, aclk, aresetn, state_reg == stb_pkg::ST_IDLE, !rq_stat.pend_valid)

endmodule

`default_nettype wire
